FILE: hw/rtl/shc_pkg.sv
// shc_pkg: shared types and codes for the session handshake controller
// holds the request command and result records passed between front, queues and back
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package shc_pkg;

   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SYN_RETRY_LIMIT   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SYN_TIMEOUT       = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IDLE_TIMEOUT      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PING_INTERVAL     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECONNECT_STEP    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECONNECT_MAX     = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECONNECT_ENABLE  = 3'd6;

   localparam logic [1:0] ACTION_TICK  = 2'd0;
   localparam logic [1:0] ACTION_OPEN  = 2'd1;
   localparam logic [1:0] ACTION_PKT   = 2'd2;
   localparam logic [1:0] ACTION_CLOSE = 2'd3;

   localparam logic [2:0] RX_SYN  = 3'd0;
   localparam logic [2:0] RX_RST  = 3'd1;
   localparam logic [2:0] RX_PONG = 3'd2;
   localparam logic [2:0] RX_DATA = 3'd3;

   localparam logic [1:0] TX_SYN  = 2'd0;
   localparam logic [1:0] TX_RST  = 2'd1;
   localparam logic [1:0] TX_ACK  = 2'd2;
   localparam logic [1:0] TX_PING = 2'd3;

   localparam logic [1:0] LINK_CLOSED    = 2'd0;
   localparam logic [1:0] LINK_PENDING   = 2'd1;
   localparam logic [1:0] LINK_CONNECTED = 2'd2;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_TICK,
      OP_OPEN,
      OP_CLOSE,
      OP_RX_SYN,
      OP_RX_RST,
      OP_RX_PONG,
      OP_RX_DATA
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] session;
      logic        session_closed;
      logic        session_init_ok;
   } cmd_type;

   typedef struct packed {
      logic        send_valid;
      logic [1:0]  send_kind;
      logic [31:0] send_session;
      logic [1:0]  link_state;
      logic        deliver_data;
      logic        session_reset;
   } result_type;

endpackage

`default_nettype wire

FILE: hw/rtl/shc_front.sv
// shc_front: decodes a request into a command for the back end
// drops bad-checksum and unknown packets here; uses shc_pkg
`timescale 1ns / 1ps
`default_nettype none

module shc_front (
   input  wire logic [1:0]       req_action,
   input  wire logic [2:0]       req_packet_kind,
   input  wire logic [31:0]      req_packet_session,
   input  wire logic             req_checksum_ok,
   input  wire logic             req_session_closed,
   input  wire logic             req_session_init_ok,
   output shc_pkg::cmd_type      cmd
);
   import shc_pkg::*;

   op_type op;

   always_comb begin
      op = OP_NOP;
      case (req_action)
         ACTION_TICK:  op = OP_TICK;
         ACTION_OPEN:  op = OP_OPEN;
         ACTION_CLOSE: op = OP_CLOSE;
         ACTION_PKT: begin
            if (req_checksum_ok) begin
               case (req_packet_kind)
                  RX_SYN:  op = OP_RX_SYN;
                  RX_RST:  op = OP_RX_RST;
                  RX_PONG: op = OP_RX_PONG;
                  RX_DATA: op = OP_RX_DATA;
                  default: op = OP_NOP;
               endcase
            end
         end
         default: op = OP_NOP;
      endcase
   end

   assign cmd.op              = op;
   assign cmd.session         = req_packet_session;
   assign cmd.session_closed  = req_session_closed;
   assign cmd.session_init_ok = req_session_init_ok;

endmodule

`default_nettype wire

FILE: hw/rtl/shc_queue.sv
// shc_queue: two-entry queue of WIDTH-bit records, head always on the output
// used between front and back and on the result side; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module shc_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output      logic             full,
   input  wire logic             pop,
   output      logic [WIDTH-1:0] head,
   output      logic             empty
);

   logic [1:0]       count_ff, count_in;
   logic [WIDTH-1:0] head_ff, head_in;
   logic [WIDTH-1:0] tail_ff, tail_in;
   logic             push_ok, pop_ok;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign head    = head_ff;

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 2'd1;
         if (count_ff == 2'd0) begin
            head_in = push_data;
         end else begin
            tail_in = push_data;
         end
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 2'd1;
         head_in  = tail_ff;
      end else if (pop_ok && push_ok) begin
         if (count_ff == 2'd1) begin
            head_in = push_data;
         end else begin
            head_in = tail_ff;
            tail_in = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

`default_nettype wire

FILE: hw/rtl/shc_back.sv
// shc_back: connection state, timers, reconnect scheduling and control registers
// executes one command per cycle, while the result side has room, into a result record; uses shc_pkg
`timescale 1ns / 1ps
`default_nettype none

module shc_back #(
   parameter int TIMER_BITS = 16,
   parameter int RETRY_BITS = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write,
   input  wire logic [shc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [shc_pkg::CSR_DATA_BITS-1:0]     csr_data,
   input  wire logic                                  cmd_valid,
   input  wire shc_pkg::cmd_type                      cmd,
   output      logic                                  cmd_take,
   input  wire logic                                  rsp_room,
   output      logic                                  rsp_push,
   output      shc_pkg::result_type                   rsp
);
   import shc_pkg::*;

   localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
   localparam int SW = CW + 1;
   localparam int RW = (RETRY_BITS > 8) ? RETRY_BITS : 8;
   localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};
   localparam logic [RETRY_BITS-1:0] RMAX = {RETRY_BITS{1'b1}};

   typedef enum logic [1:0] {
      ST_CLOSED    = LINK_CLOSED,
      ST_PENDING   = LINK_PENDING,
      ST_CONNECTED = LINK_CONNECTED
   } state_type;

   logic [7:0]  limit_ff;
   logic [15:0] syn_to_ff, idle_to_ff, ping_iv_ff, step_ff, rmax_ff;
   logic        ren_ff;

   state_type             state_ff, state_in;
   logic                  sock_ff, sock_in;
   logic [31:0]           active_ff, active_in;
   logic [RETRY_BITS-1:0] retries_ff, retries_in;
   logic [TIMER_BITS-1:0] syn_el_ff, syn_el_in;
   logic [TIMER_BITS-1:0] idle_el_ff, idle_el_in;
   logic                  armed_ff, armed_in;
   logic [TIMER_BITS-1:0] ping_el_ff, ping_el_in;
   logic                  rp_ff, rp_in;
   logic [TIMER_BITS-1:0] rleft_ff, rleft_in;
   logic [TIMER_BITS-1:0] rdelay_ff, rdelay_in;

   logic       fire;
   logic       do_reset;
   logic       started;
   logic [SW-1:0] dsum;
   result_type res;

   assign fire     = cmd_valid && rsp_room;
   assign cmd_take = fire;
   assign rsp_push = fire;
   assign rsp      = res;

   always_comb begin
      state_in   = state_ff;
      sock_in    = sock_ff;
      active_in  = active_ff;
      retries_in = retries_ff;
      syn_el_in  = syn_el_ff;
      idle_el_in = idle_el_ff;
      armed_in   = armed_ff;
      ping_el_in = ping_el_ff;
      rp_in      = rp_ff;
      rleft_in   = rleft_ff;
      rdelay_in  = rdelay_ff;
      do_reset   = 1'b0;
      started    = 1'b0;
      dsum       = '0;
      res        = '0;

      case (cmd.op)
         OP_TICK: begin
            syn_el_in  = (syn_el_ff == TMAX) ? TMAX : syn_el_ff + 1'b1;
            idle_el_in = (idle_el_ff == TMAX) ? TMAX : idle_el_ff + 1'b1;
            ping_el_in = (ping_el_ff == TMAX) ? TMAX : ping_el_ff + 1'b1;
            if (sock_ff) begin
               if (rp_ff) begin
                  if (rleft_ff <= TIMER_BITS'(1)) begin
                     rp_in    = 1'b0;
                     rleft_in = '0;
                     if (state_ff == ST_CLOSED) begin
                        started = 1'b1;
                     end
                  end else begin
                     rleft_in = rleft_ff - 1'b1;
                  end
               end
               if (!started) begin
                  if (state_ff == ST_PENDING) begin
                     if (RW'(retries_ff) >= RW'(limit_ff)) begin
                        do_reset = 1'b1;
                     end else if (CW'(syn_el_in) >= CW'(syn_to_ff)) begin
                        if (retries_ff != RMAX) begin
                           retries_in = retries_ff + 1'b1;
                        end
                        syn_el_in          = '0;
                        res.send_valid     = 1'b1;
                        res.send_kind      = TX_SYN;
                     end
                  end else if (state_ff == ST_CONNECTED) begin
                     if (armed_ff && (CW'(idle_el_in) >= CW'(idle_to_ff))) begin
                        do_reset = 1'b1;
                     end else if (cmd.session_closed) begin
                        do_reset = 1'b1;
                     end else if (CW'(ping_el_in) >= CW'(ping_iv_ff)) begin
                        ping_el_in       = '0;
                        res.send_valid   = 1'b1;
                        res.send_kind    = TX_PING;
                        res.send_session = active_ff;
                     end
                  end
               end
            end
         end
         OP_OPEN: begin
            sock_in = 1'b1;
            if (state_ff == ST_CLOSED) begin
               started = 1'b1;
            end
         end
         OP_CLOSE: begin
            if (state_ff == ST_CONNECTED) begin
               res.send_valid   = 1'b1;
               res.send_kind    = TX_RST;
               res.send_session = active_ff;
            end
            rp_in    = 1'b0;
            rleft_in = '0;
            sock_in  = 1'b0;
            state_in = ST_CLOSED;
         end
         OP_RX_SYN: begin
            if (sock_ff) begin
               if (state_ff == ST_CONNECTED) begin
                  res.send_valid   = 1'b1;
                  res.send_kind    = (active_ff == cmd.session) ? TX_ACK : TX_RST;
                  res.send_session = cmd.session;
               end else if (state_ff == ST_PENDING) begin
                  if (cmd.session_init_ok) begin
                     active_in        = cmd.session;
                     state_in         = ST_CONNECTED;
                     ping_el_in       = '0;
                     res.send_valid   = 1'b1;
                     res.send_kind    = TX_ACK;
                     res.send_session = cmd.session;
                  end
               end else begin
                  res.send_valid   = 1'b1;
                  res.send_kind    = TX_RST;
                  res.send_session = cmd.session;
               end
            end
         end
         OP_RX_RST: begin
            if (sock_ff) begin
               do_reset = 1'b1;
            end
         end
         OP_RX_PONG, OP_RX_DATA: begin
            if (sock_ff) begin
               if (state_ff == ST_CONNECTED) begin
                  idle_el_in       = '0;
                  armed_in         = 1'b1;
                  res.deliver_data = (cmd.op == OP_RX_DATA);
               end else begin
                  res.send_valid   = 1'b1;
                  res.send_kind    = TX_RST;
                  res.send_session = cmd.session;
               end
            end
         end
         default: begin
         end
      endcase

      if (started) begin
         res.send_valid   = 1'b1;
         res.send_kind    = TX_SYN;
         res.send_session = '0;
         state_in         = ST_PENDING;
         retries_in       = '0;
         syn_el_in        = '0;
      end

      if (do_reset) begin
         state_in          = ST_CLOSED;
         res.session_reset = 1'b1;
         if (sock_in && ren_ff && !rp_in) begin
            dsum = SW'(rdelay_ff) + SW'(step_ff);
            if (dsum > SW'(TMAX)) begin
               dsum = SW'(TMAX);
            end
            if (dsum > SW'(rmax_ff)) begin
               dsum = SW'(rmax_ff);
            end
            rdelay_in = dsum[TIMER_BITS-1:0];
            rp_in     = 1'b1;
            rleft_in  = dsum[TIMER_BITS-1:0];
         end
      end

      res.link_state = state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= 8'd5;
         syn_to_ff  <= 16'd10;
         idle_to_ff <= 16'd300;
         ping_iv_ff <= 16'd100;
         step_ff    <= 16'd5;
         rmax_ff    <= 16'd100;
         ren_ff     <= 1'b1;
         state_ff   <= ST_CLOSED;
         sock_ff    <= 1'b0;
         active_ff  <= '0;
         retries_ff <= '0;
         syn_el_ff  <= '0;
         idle_el_ff <= '0;
         armed_ff   <= 1'b0;
         ping_el_ff <= '0;
         rp_ff      <= 1'b0;
         rleft_ff   <= '0;
         rdelay_ff  <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_SYN_RETRY_LIMIT:  limit_ff   <= csr_data[7:0];
               CSR_SYN_TIMEOUT:      syn_to_ff  <= csr_data;
               CSR_IDLE_TIMEOUT:     idle_to_ff <= csr_data;
               CSR_PING_INTERVAL:    ping_iv_ff <= csr_data;
               CSR_RECONNECT_STEP:   step_ff    <= csr_data;
               CSR_RECONNECT_MAX:    rmax_ff    <= csr_data;
               CSR_RECONNECT_ENABLE: ren_ff     <= csr_data[0];
               default: begin
               end
            endcase
         end
         if (fire) begin
            state_ff   <= state_in;
            sock_ff    <= sock_in;
            active_ff  <= active_in;
            retries_ff <= retries_in;
            syn_el_ff  <= syn_el_in;
            idle_el_ff <= idle_el_in;
            armed_ff   <= armed_in;
            ping_el_ff <= ping_el_in;
            rp_ff      <= rp_in;
            rleft_ff   <= rleft_in;
            rdelay_ff  <= rdelay_in;
         end
      end
   end

`ifndef SYNTHESIS
   a_closed_socket_link_closed: assert property (@(posedge clock) disable iff (reset)
      !sock_ff |-> (state_ff == ST_CLOSED))
      else $error("link left closed while socket closed");

   a_no_countdown_without_pending: assert property (@(posedge clock) disable iff (reset)
      !rp_ff |-> (rleft_ff == '0))
      else $error("reconnect countdown running with no reconnect pending");

   a_reset_ends_closed: assert property (@(posedge clock) disable iff (reset)
      (fire && res.session_reset) |=> (state_ff == ST_CLOSED))
      else $error("session reset did not leave link closed");

   a_deliver_only_connected: assert property (@(posedge clock) disable iff (reset)
      (fire && res.deliver_data) |-> (state_ff == ST_CONNECTED))
      else $error("data delivered outside a connected session");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/session_handshake_controller_core.sv
// session_handshake_controller_core: top level of the session handshake controller
// instantiates shc_front, shc_queue (command and result side) and shc_back; uses shc_pkg
//
// requests enter on req_push / req_full: tick, open, close or a received packet header.
// a request is taken at a rising edge with req_push high and req_full low. every request
// yields exactly one result, presented on the rsp_ ports while rsp_empty is low and taken
// at a rising edge with rsp_pop high. results come out in request order.
// the front decodes each request into a command held in a two-entry queue; the back
// executes each command against the connection state and timers and writes the result into
// a second two-entry queue, one command per cycle while that queue has room.
// a taken request passes through the command queue and the back into the result queue.
// throughput: one request per cycle while the result queue has room.
// when rsp_pop stays low, the result queue fills, the back holds, the command queue fills
// and req_full rises; nothing is dropped.
// csr_write with csr_index / csr_data sets a control register in the same edge; write only
// while no request is in flight. synchronous reset empties both queues, closes the link
// and restores register defaults.
`timescale 1ns / 1ps
`default_nettype none

module session_handshake_controller_core #(
   parameter int TIMER_BITS = 16,
   parameter int RETRY_BITS = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write,
   input  wire logic [shc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [shc_pkg::CSR_DATA_BITS-1:0]  csr_data,
   input  wire logic                               req_push,
   output      logic                               req_full,
   input  wire logic [1:0]                         req_action,
   input  wire logic [2:0]                         req_packet_kind,
   input  wire logic [31:0]                        req_packet_session,
   input  wire logic                               req_checksum_ok,
   input  wire logic                               req_session_closed,
   input  wire logic                               req_session_init_ok,
   output      logic                               rsp_empty,
   input  wire logic                               rsp_pop,
   output      logic                               rsp_send_valid,
   output      logic [1:0]                         rsp_send_kind,
   output      logic [31:0]                        rsp_send_session,
   output      logic [1:0]                         rsp_link_state,
   output      logic                               rsp_deliver_data,
   output      logic                               rsp_session_reset
);
   import shc_pkg::*;

   cmd_type    front_cmd;
   cmd_type    queued_cmd;
   logic       cmd_empty;
   logic       cmd_take;
   logic       rsp_full;
   logic       rsp_push;
   result_type back_rsp;
   result_type head_rsp;

   shc_front u_front (
      .req_action          (req_action),
      .req_packet_kind     (req_packet_kind),
      .req_packet_session  (req_packet_session),
      .req_checksum_ok     (req_checksum_ok),
      .req_session_closed  (req_session_closed),
      .req_session_init_ok (req_session_init_ok),
      .cmd                 (front_cmd)
   );

   shc_queue #(
      .WIDTH ($bits(cmd_type))
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_cmd),
      .full      (req_full),
      .pop       (cmd_take),
      .head      (queued_cmd),
      .empty     (cmd_empty)
   );

   shc_back #(
      .TIMER_BITS (TIMER_BITS),
      .RETRY_BITS (RETRY_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd_valid (!cmd_empty),
      .cmd       (queued_cmd),
      .cmd_take  (cmd_take),
      .rsp_room  (!rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (back_rsp)
   );

   shc_queue #(
      .WIDTH ($bits(result_type))
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (back_rsp),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .head      (head_rsp),
      .empty     (rsp_empty)
   );

   assign rsp_send_valid    = head_rsp.send_valid;
   assign rsp_send_kind     = head_rsp.send_kind;
   assign rsp_send_session  = head_rsp.send_session;
   assign rsp_link_state    = head_rsp.link_state;
   assign rsp_deliver_data  = head_rsp.deliver_data;
   assign rsp_session_reset = head_rsp.session_reset;

endmodule

`default_nettype wire

FILE: bench/session_handshake_controller_core_test.sv
// session_handshake_controller_core_test: self-checking bench for the session handshake core
// directed request table then random phases with register changes, checked by a link predictor
// depends on shc_pkg and session_handshake_controller_core
`timescale 1ns / 1ps

module session_handshake_controller_core_test;
   import shc_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int PHASES = 7;
   localparam int ITEMS_PER_PHASE = 250;
   localparam logic [1:0] NO_KIND = 2'd0;
   localparam logic [2:0] RX_UNKNOWN_TOP = 3'd7;

   typedef struct packed {
      logic [1:0]  action;
      logic [2:0]  kind;
      logic [31:0] session;
      logic        csum;
      logic        sclosed;
      logic        init_ok;
   } request_type;

   typedef struct packed {
      request_type rq;
      logic        typed;
      result_type  want;
   } vector_type;

   logic clock;
   logic reset;
   logic csr_write;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_data;
   logic req_push;
   logic req_full;
   logic [1:0] req_action;
   logic [2:0] req_packet_kind;
   logic [31:0] req_packet_session;
   logic req_checksum_ok;
   logic req_session_closed;
   logic req_session_init_ok;
   logic rsp_empty;
   logic rsp_pop;
   logic rsp_send_valid;
   logic [1:0] rsp_send_kind;
   logic [31:0] rsp_send_session;
   logic [1:0] rsp_link_state;
   logic rsp_deliver_data;
   logic rsp_session_reset;

   // predictor copy of the registers and link state
   logic [7:0]  cfg_retry_limit;
   logic [15:0] cfg_syn_timeout, cfg_idle_timeout, cfg_ping_interval;
   logic [15:0] cfg_rc_step, cfg_rc_max;
   logic        cfg_rc_enable;
   logic [1:0]  lk_state;
   logic        lk_open;
   logic [31:0] lk_session;
   logic [7:0]  lk_retries;
   logic [15:0] lk_syn_elapsed, lk_idle_elapsed, lk_ping_elapsed;
   logic        lk_idle_armed;
   logic        lk_rc_pending;
   logic [15:0] lk_rc_left, lk_rc_delay;
   result_type  link_out;

   result_type pending_results [$];
   vector_type directed_rows [$];
   int         errors = 0;
   int         cycles = 0;
   logic       calm = 1'b0;
   int         stall_left = 0;

   session_handshake_controller_core u_top (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_action          (req_action),
      .req_packet_kind     (req_packet_kind),
      .req_packet_session  (req_packet_session),
      .req_checksum_ok     (req_checksum_ok),
      .req_session_closed  (req_session_closed),
      .req_session_init_ok (req_session_init_ok),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_send_valid      (rsp_send_valid),
      .rsp_send_kind       (rsp_send_kind),
      .rsp_send_session    (rsp_send_session),
      .rsp_link_state      (rsp_link_state),
      .rsp_deliver_data    (rsp_deliver_data),
      .rsp_session_reset   (rsp_session_reset)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic void send_packet(input logic [1:0] kind, input logic [31:0] session);
      link_out.send_valid = 1'b1;
      link_out.send_kind = kind;
      link_out.send_session = session;
   endfunction

   function automatic void start_pending();
      send_packet(TX_SYN, 32'd0);
      lk_state = LINK_PENDING;
      lk_retries = 8'd0;
      lk_syn_elapsed = 16'd0;
   endfunction

   function automatic void drop_session();
      logic [16:0] delay;
      lk_state = LINK_CLOSED;
      link_out.session_reset = 1'b1;
      if (!lk_open || !cfg_rc_enable || lk_rc_pending) return;
      delay = {1'b0, lk_rc_delay} + {1'b0, cfg_rc_step};
      if (delay > 17'h0FFFF) delay = 17'h0FFFF;
      if (delay > {1'b0, cfg_rc_max}) delay = {1'b0, cfg_rc_max};
      lk_rc_delay = delay[15:0];
      lk_rc_pending = 1'b1;
      lk_rc_left = lk_rc_delay;
   endfunction

   function automatic result_type link_step(input request_type rq);
      logic fired;
      link_out = '0;
      fired = 1'b0;
      case (rq.action)
         ACTION_TICK: begin
            lk_syn_elapsed = sat_inc(lk_syn_elapsed);
            lk_idle_elapsed = sat_inc(lk_idle_elapsed);
            lk_ping_elapsed = sat_inc(lk_ping_elapsed);
            if (lk_open) begin
               if (lk_rc_pending) begin
                  if (lk_rc_left <= 16'd1) begin
                     lk_rc_pending = 1'b0;
                     lk_rc_left = 16'd0;
                     if (lk_state == LINK_CLOSED) begin
                        start_pending();
                        fired = 1'b1;
                     end
                  end else begin
                     lk_rc_left = lk_rc_left - 16'd1;
                  end
               end
               if (!fired && lk_state == LINK_PENDING) begin
                  if (lk_retries >= cfg_retry_limit) begin
                     drop_session();
                  end else if (lk_syn_elapsed >= cfg_syn_timeout) begin
                     if (lk_retries != 8'hFF) lk_retries = lk_retries + 8'd1;
                     lk_syn_elapsed = 16'd0;
                     send_packet(TX_SYN, 32'd0);
                  end
               end else if (!fired && lk_state == LINK_CONNECTED) begin
                  if (lk_idle_armed && lk_idle_elapsed >= cfg_idle_timeout) begin
                     drop_session();
                  end else if (rq.sclosed) begin
                     drop_session();
                  end else if (lk_ping_elapsed >= cfg_ping_interval) begin
                     lk_ping_elapsed = 16'd0;
                     send_packet(TX_PING, lk_session);
                  end
               end
            end
         end
         ACTION_OPEN: begin
            lk_open = 1'b1;
            if (lk_state == LINK_CLOSED) start_pending();
         end
         ACTION_PKT: begin
            if (lk_open && rq.csum) begin
               case (rq.kind)
                  RX_SYN: begin
                     if (lk_state == LINK_CONNECTED) begin
                        send_packet((lk_session == rq.session) ? TX_ACK : TX_RST, rq.session);
                     end else if (lk_state == LINK_PENDING) begin
                        if (rq.init_ok) begin
                           lk_session = rq.session;
                           lk_state = LINK_CONNECTED;
                           lk_ping_elapsed = 16'd0;
                           send_packet(TX_ACK, rq.session);
                        end
                     end else begin
                        send_packet(TX_RST, rq.session);
                     end
                  end
                  RX_RST: drop_session();
                  RX_PONG, RX_DATA: begin
                     if (lk_state == LINK_CONNECTED) begin
                        lk_idle_elapsed = 16'd0;
                        lk_idle_armed = 1'b1;
                        if (rq.kind == RX_DATA) link_out.deliver_data = 1'b1;
                     end else begin
                        send_packet(TX_RST, rq.session);
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: begin
            if (lk_state == LINK_CONNECTED) send_packet(TX_RST, lk_session);
            lk_rc_pending = 1'b0;
            lk_rc_left = 16'd0;
            lk_open = 1'b0;
            lk_state = LINK_CLOSED;
         end
      endcase
      link_out.link_state = lk_state;
      return link_out;
   endfunction

   function automatic request_type mk_request(input logic [1:0] action, input logic [2:0] kind,
                                              input logic [31:0] session, input logic csum,
                                              input logic sclosed, input logic init_ok);
      return '{action, kind, session, csum, sclosed, init_ok};
   endfunction

   function automatic result_type mk_result(input logic valid, input logic [1:0] kind,
                                            input logic [31:0] session, input logic [1:0] link,
                                            input logic deliver, input logic rst);
      return '{valid, kind, session, link, deliver, rst};
   endfunction

   function automatic vector_type row(input request_type rq, input logic typed,
                                      input result_type want);
      return '{rq, typed, want};
   endfunction

   function automatic request_type random_request();
      request_type rq;
      int pick;
      rq.action = ACTION_TICK;
      rq.kind = 3'($urandom_range(0, 7));
      rq.session = $urandom;
      rq.csum = ($urandom_range(0, 15) != 0);
      rq.sclosed = ($urandom_range(0, 1) == 0);
      rq.init_ok = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         rq.sclosed = ($urandom_range(0, 29) == 0);
      end else if (pick < 54) begin
         rq.action = ACTION_OPEN;
      end else if (pick < 56) begin
         rq.action = ACTION_CLOSE;
      end else begin
         rq.action = ACTION_PKT;
         pick = $urandom_range(0, 99);
         if (pick < 5) rq.kind = 3'($urandom_range(4, 7));
         else if (pick < 40) rq.kind = RX_SYN;
         else if (pick < 45) rq.kind = RX_RST;
         else if (pick < 72) rq.kind = RX_PONG;
         else rq.kind = RX_DATA;
         pick = $urandom_range(0, 99);
         if (pick < 50) rq.session = lk_session;
         else if (pick < 65) rq.session = 32'd0;
         else if (pick < 75) rq.session = 32'hFFFF_FFFF;
      end
      return rq;
   endfunction

   task automatic push_request(input request_type rq, input logic typed, input result_type want);
      result_type predicted;
      req_push <= 1'b1;
      req_action <= rq.action;
      req_packet_kind <= rq.kind;
      req_packet_session <= rq.session;
      req_checksum_ok <= rq.csum;
      req_session_closed <= rq.sclosed;
      req_session_init_ok <= rq.init_ok;
      do @(posedge clock); while (req_full);
      predicted = link_step(rq);
      pending_results.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                 input logic [CSR_DATA_BITS-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      case (idx)
         CSR_SYN_RETRY_LIMIT:  cfg_retry_limit = data[7:0];
         CSR_SYN_TIMEOUT:      cfg_syn_timeout = data;
         CSR_IDLE_TIMEOUT:     cfg_idle_timeout = data;
         CSR_PING_INTERVAL:    cfg_ping_interval = data;
         CSR_RECONNECT_STEP:   cfg_rc_step = data;
         CSR_RECONNECT_MAX:    cfg_rc_max = data;
         CSR_RECONNECT_ENABLE: cfg_rc_enable = data[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // random stalls on the result side
   always @(negedge clock) begin
      if (calm) begin
         rsp_pop <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_pop <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_pop <= 1'b0;
         stall_left <= $urandom_range(0, 11);
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      result_type got;
      result_type want;
      got = '{rsp_send_valid, rsp_send_kind, rsp_send_session, rsp_link_state,
              rsp_deliver_data, rsp_session_reset};
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_results.size() == 0) begin
            if (errors < 10) $display("result with no request outstanding: v=%0d k=%0d s=%08h",
                                      got.send_valid, got.send_kind, got.send_session);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (got.send_valid !== want.send_valid || got.send_kind !== want.send_kind ||
                got.send_session !== want.send_session ||
                got.link_state !== want.link_state ||
                got.deliver_data !== want.deliver_data ||
                got.session_reset !== want.session_reset) begin
               if (errors < 10) begin
                  $display("mismatch: want v=%0d k=%0d s=%08h l=%0d d=%0d r=%0d",
                           want.send_valid, want.send_kind, want.send_session,
                           want.link_state, want.deliver_data, want.session_reset);
                  $display("          got  v=%0d k=%0d s=%08h l=%0d d=%0d r=%0d",
                           got.send_valid, got.send_kind, got.send_session,
                           got.link_state, got.deliver_data, got.session_reset);
               end
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("session_handshake_controller_core_test: errors");
         $finish;
      end
   end

   initial begin : stimulus
      logic [CSR_INDEX_BITS-1:0] regs [0:6];
      int lo [0:6];
      int hi [0:6];
      int sm [0:6];
      logic [CSR_DATA_BITS-1:0] value;
      int gap_pct;

      clock = 1'b0;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_push = 1'b0;
      req_action = ACTION_TICK;
      req_packet_kind = RX_SYN;
      req_packet_session = 32'd0;
      req_checksum_ok = 1'b0;
      req_session_closed = 1'b0;
      req_session_init_ok = 1'b0;
      rsp_pop = 1'b0;

      cfg_retry_limit = 8'd5;
      cfg_syn_timeout = 16'd10;
      cfg_idle_timeout = 16'd300;
      cfg_ping_interval = 16'd100;
      cfg_rc_step = 16'd5;
      cfg_rc_max = 16'd100;
      cfg_rc_enable = 1'b1;
      lk_state = LINK_CLOSED;
      lk_open = 1'b0;
      lk_session = 32'd0;
      lk_retries = 8'd0;
      lk_syn_elapsed = 16'd0;
      lk_idle_elapsed = 16'd0;
      lk_ping_elapsed = 16'd0;
      lk_idle_armed = 1'b0;
      lk_rc_pending = 1'b0;
      lk_rc_left = 16'd0;
      lk_rc_delay = 16'd0;

      regs = '{CSR_SYN_RETRY_LIMIT, CSR_SYN_TIMEOUT, CSR_IDLE_TIMEOUT, CSR_PING_INTERVAL,
               CSR_RECONNECT_STEP, CSR_RECONNECT_MAX, CSR_RECONNECT_ENABLE};
      lo = '{0, 1, 1, 1, 1, 1, 0};
      hi = '{255, 65535, 65535, 65535, 65535, 65535, 1};
      sm = '{6, 12, 40, 30, 8, 30, 1};

      // closed socket, then open / handshake / traffic / reset / reconnect / close
      directed_rows.push_back(row(mk_request(ACTION_TICK, RX_SYN, 32'd0, 1'b0, 1'b0, 1'b0),
         1'b1, mk_result(1'b0, NO_KIND, 32'd0, LINK_CLOSED, 1'b0, 1'b0)));
      directed_rows.push_back(row(mk_request(ACTION_PKT, RX_SYN, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1),
         1'b1, mk_result(1'b0, NO_KIND, 32'd0, LINK_CLOSED, 1'b0, 1'b0)));
      directed_rows.push_back(row(mk_request(ACTION_OPEN, RX_SYN, 32'd0, 1'b0, 1'b0, 1'b0),
         1'b1, mk_result(1'b1, TX_SYN, 32'd0, LINK_PENDING, 1'b0, 1'b0)));
      directed_rows.push_back(row(mk_request(ACTION_OPEN, RX_SYN, 32'd0, 1'b0, 1'b0, 1'b0),
         1'b1, mk_result(1'b0, NO_KIND, 32'd0, LINK_PENDING, 1'b0, 1'b0)));
      directed_rows.push_back(row(mk_request(ACTION_PKT, RX_SYN, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0),
         1'b1, mk_result(1'b0, NO_KIND, 32'd0, LINK_PENDING, 1'b0, 1'b0)));
      directed_rows.push_back(row(mk_request(ACTION_PKT, RX_SYN, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1),
         1'b1, mk_result(1'b0, NO_KIND, 32'd0, LINK_PENDING, 1'b0, 1'b0)));
      directed_rows.push_back(row(mk_request(ACTION_PKT, RX_UNKNOWN_TOP, 32'hFFFF_FFFF, 1'b1, 1'b1,
         1'b1), 1'b1, mk_result(1'b0, NO_KIND, 32'd0, LINK_PENDING, 1'b0, 1'b0)));
      directed_rows.push_back(row(mk_request(ACTION_PKT, RX_SYN, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1),
         1'b1, mk_result(1'b1, TX_ACK, 32'hFFFF_FFFF, LINK_CONNECTED, 1'b0, 1'b0)));
      directed_rows.push_back(row(mk_request(ACTION_PKT, RX_SYN, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0),
         1'b1, mk_result(1'b1, TX_ACK, 32'hFFFF_FFFF, LINK_CONNECTED, 1'b0, 1'b0)));
      directed_rows.push_back(row(mk_request(ACTION_PKT, RX_SYN, 32'd0, 1'b1, 1'b0, 1'b0),
         1'b1, mk_result(1'b1, TX_RST, 32'd0, LINK_CONNECTED, 1'b0, 1'b0)));
      directed_rows.push_back(row(mk_request(ACTION_OPEN, RX_SYN, 32'd0, 1'b0, 1'b0, 1'b0),
         1'b1, mk_result(1'b0, NO_KIND, 32'd0, LINK_CONNECTED, 1'b0, 1'b0)));
      directed_rows.push_back(row(mk_request(ACTION_PKT, RX_PONG, 32'd0, 1'b1, 1'b0, 1'b0),
         1'b1, mk_result(1'b0, NO_KIND, 32'd0, LINK_CONNECTED, 1'b0, 1'b0)));
      directed_rows.push_back(row(mk_request(ACTION_PKT, RX_DATA, 32'd0, 1'b1, 1'b0, 1'b0),
         1'b1, mk_result(1'b0, NO_KIND, 32'd0, LINK_CONNECTED, 1'b1, 1'b0)));
      directed_rows.push_back(row(mk_request(ACTION_TICK, RX_SYN, 32'd0, 1'b0, 1'b1, 1'b0),
         1'b1, mk_result(1'b0, NO_KIND, 32'd0, LINK_CLOSED, 1'b0, 1'b1)));
      directed_rows.push_back(row(mk_request(ACTION_PKT, RX_PONG, 32'h1234_5678, 1'b1, 1'b0, 1'b0),
         1'b1, mk_result(1'b1, TX_RST, 32'h1234_5678, LINK_CLOSED, 1'b0, 1'b0)));
      directed_rows.push_back(row(mk_request(ACTION_PKT, RX_DATA, 32'h8765_4321, 1'b1, 1'b0, 1'b0),
         1'b1, mk_result(1'b1, TX_RST, 32'h8765_4321, LINK_CLOSED, 1'b0, 1'b0)));
      directed_rows.push_back(row(mk_request(ACTION_PKT, RX_SYN, 32'hA5A5_5A5A, 1'b1, 1'b0, 1'b0),
         1'b1, mk_result(1'b1, TX_RST, 32'hA5A5_5A5A, LINK_CLOSED, 1'b0, 1'b0)));
      // reconnect countdown, the last tick fires a new syn
      repeat (5) directed_rows.push_back(row(mk_request(ACTION_TICK, RX_SYN, 32'd0, 1'b0, 1'b0,
         1'b0), 1'b0, '0));
      directed_rows.push_back(row(mk_request(ACTION_PKT, RX_RST, 32'd0, 1'b1, 1'b0, 1'b0),
         1'b1, mk_result(1'b0, NO_KIND, 32'd0, LINK_CLOSED, 1'b0, 1'b1)));
      directed_rows.push_back(row(mk_request(ACTION_CLOSE, RX_SYN, 32'd0, 1'b0, 1'b0, 1'b0),
         1'b1, mk_result(1'b0, NO_KIND, 32'd0, LINK_CLOSED, 1'b0, 1'b0)));
      directed_rows.push_back(row(mk_request(ACTION_OPEN, RX_SYN, 32'd0, 1'b0, 1'b0, 1'b0),
         1'b0, '0));
      directed_rows.push_back(row(mk_request(ACTION_PKT, RX_SYN, 32'd0, 1'b1, 1'b0, 1'b1),
         1'b0, '0));
      directed_rows.push_back(row(mk_request(ACTION_CLOSE, RX_SYN, 32'd0, 1'b0, 1'b0, 1'b0),
         1'b1, mk_result(1'b1, TX_RST, 32'd0, LINK_CLOSED, 1'b0, 1'b0)));

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         if ($urandom_range(0, 3) == 0) begin
            req_push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
         push_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         // drain before touching the registers
         req_push <= 1'b0;
         while (pending_results.size() != 0) @(negedge clock);
         repeat (4) @(negedge clock);
         for (int r = 0; r < 7; r++) begin
            if (phase == 1) value = CSR_DATA_BITS'(lo[r]);
            else if (phase == 2) value = CSR_DATA_BITS'(hi[r]);
            else if (phase == 3 || $urandom_range(0, 5) == 0)
               value = $urandom_range(0, 1) ? CSR_DATA_BITS'(hi[r]) : CSR_DATA_BITS'(lo[r]);
            else value = CSR_DATA_BITS'($urandom_range(lo[r], sm[r]));
            write_register(regs[r], value);
         end
         csr_write <= 1'b0;
         calm = (phase == PHASES - 1);
         gap_pct = (phase % 3 == 0) ? 0 : $urandom_range(5, 25);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (!calm && $urandom_range(0, 99) < gap_pct) begin
               req_push <= 1'b0;
               repeat ($urandom_range(1, 12)) @(negedge clock);
            end
            push_request(random_request(), 1'b0, '0);
         end
      end

      req_push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("session_handshake_controller_core_test: clean");
      end else begin
         $display("session_handshake_controller_core_test: errors");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/shc_pkg.sv
hw/rtl/shc_front.sv
hw/rtl/shc_queue.sv
hw/rtl/shc_back.sv
hw/rtl/session_handshake_controller_core.sv
bench/session_handshake_controller_core_test.sv
